/* hw/rtl/kpd_pkg.sv */
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared constants, keymap ROMs and lane result type for the key matrix
// scan decoder.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int ROW_COUNT    = 9;
    localparam int COLUMN_COUNT = 8;
    localparam int MAP_ROWS     = 9;
    localparam int MAP_COLS     = 8;
    localparam int ROW_W        = 8;
    localparam int CODE_W       = 8;
    localparam int ROW_IDX_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SHIFT_BIT    = 7;

    localparam logic [CODE_W-1:0] CODE_NONE = '0;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
    } lane_res_t;

    localparam logic [CODE_W-1:0] MAP_PLAIN [0:MAP_ROWS-1][0:MAP_COLS-1] = '{
        '{8'h86, 8'h1b, 8'h7f, 8'h98, 8'h71, 8'h61, 8'h60, 8'h00},
        '{8'h85, 8'h96, 8'h92, 8'h32, 8'h77, 8'h73, 8'h7a, 8'h00},
        '{8'h84, 8'h82, 8'h20, 8'h33, 8'h65, 8'h64, 8'h78, 8'h00},
        '{8'h83, 8'h31, 8'h09, 8'h34, 8'h72, 8'h66, 8'h63, 8'h5b},
        '{8'h99, 8'h97, 8'h0d, 8'h35, 8'h74, 8'h67, 8'h76, 8'h5d},
        '{8'h81, 8'h3b, 8'h0a, 8'h36, 8'h79, 8'h68, 8'h62, 8'h5c},
        '{8'h80, 8'h2f, 8'h08, 8'h37, 8'h75, 8'h6a, 8'h6e, 8'h00},
        '{8'h2d, 8'h2e, 8'h30, 8'h38, 8'h69, 8'h6b, 8'h6d, 8'h00},
        '{8'h27, 8'h3d, 8'h39, 8'h70, 8'h6f, 8'h6c, 8'h2c, 8'h00}
    };

    localparam logic [CODE_W-1:0] MAP_SHIFT [0:MAP_ROWS-1][0:MAP_COLS-1] = '{
        '{8'h86, 8'h1b, 8'h7f, 8'h98, 8'h51, 8'h41, 8'h60, 8'h00},
        '{8'h85, 8'h96, 8'h92, 8'h21, 8'h57, 8'h53, 8'h5a, 8'h00},
        '{8'h84, 8'h82, 8'h20, 8'h23, 8'h45, 8'h44, 8'h58, 8'h00},
        '{8'h83, 8'h31, 8'h09, 8'h24, 8'h52, 8'h46, 8'h43, 8'h7b},
        '{8'h99, 8'h97, 8'h0d, 8'h25, 8'h54, 8'h47, 8'h56, 8'h7d},
        '{8'h81, 8'h3a, 8'h0a, 8'h5e, 8'h59, 8'h48, 8'h42, 8'h7c},
        '{8'h80, 8'h3f, 8'h08, 8'h26, 8'h55, 8'h4a, 8'h4e, 8'h00},
        '{8'h5f, 8'h3e, 8'h29, 8'h2a, 8'h49, 8'h4b, 8'h4d, 8'h00},
        '{8'h22, 8'h2b, 8'h28, 8'h50, 8'h4f, 8'h4c, 8'h3c, 8'h00}
    };

endpackage

/* hw/rtl/kpd_lane.sv */
// ----------------------------------------------------------------------------
// kpd_lane
// One row lane: finds the lowest pressed column of its row whose keymap
// code is not zero.
// ----------------------------------------------------------------------------
module kpd_lane (
    input  logic [kpd_pkg::ROW_IDX_W-1:0] row_idx,
    input  logic                          shifted,
    input  logic [kpd_pkg::ROW_W-1:0]     row,
    output kpd_pkg::lane_res_t            res
);
    import kpd_pkg::*;

    always_comb
    begin
        logic [CODE_W-1:0] code;
        res = '{found: 1'b0, code: CODE_NONE};
        for (int c = COLUMN_COUNT - 1; c >= 0; c--)
        begin
            code = CODE_NONE;
            if (c < MAP_COLS && int'(row_idx) < MAP_ROWS)
            begin
                code = shifted ? MAP_SHIFT[row_idx][c] : MAP_PLAIN[row_idx][c];
            end
            if (!row[c] && code != CODE_NONE)
            begin
                res.found = 1'b1;
                res.code  = code;
            end
        end
    end

endmodule

/* hw/rtl/kpd_merge.sv */
// ----------------------------------------------------------------------------
// kpd_merge
// Merge stage: takes the code of the first row lane that found a key.
// ----------------------------------------------------------------------------
module kpd_merge (
    input  kpd_pkg::lane_res_t          lanes [kpd_pkg::ROW_COUNT],
    output logic [kpd_pkg::CODE_W-1:0]  code
);
    import kpd_pkg::*;

    always_comb
    begin
        code = CODE_NONE;
        for (int r = ROW_COUNT - 1; r >= 0; r--)
        begin
            if (lanes[r].found)
            begin
                code = lanes[r].code;
            end
        end
    end

endmodule

/* hw/rtl/keypad_matrix_decoder_core.sv */
// ----------------------------------------------------------------------------
// keypad_matrix_decoder_core
// Key matrix scan decoder: one 9x8 snapshot in, one key report out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one snapshot (row_1 .. row_9,
// active-low columns, row_1 bit 7 is shift) per transfer.
// Output channel: out_valid / out_stall carry one report (key_code, new_key)
// per snapshot, in order.
// Nine row lanes decode their rows in parallel; a merge stage picks the first
// row with a mapped key, and the core compares its code with the kept code.
// Each transfer's report is registered in the output register, or in the skid entry while that register is held.
// Throughput: one snapshot per cycle while out_stall is low.
// A two-entry output buffer lets one more snapshot in while a report waits;
// in_stall rises only when both entries are full.
// Reset clears the kept code to zero and empties the output buffer.
// While out_stall is high the pending report holds unchanged.
// ----------------------------------------------------------------------------
module keypad_matrix_decoder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [kpd_pkg::ROW_W-1:0]    row_1,
    input  logic [kpd_pkg::ROW_W-1:0]    row_2,
    input  logic [kpd_pkg::ROW_W-1:0]    row_3,
    input  logic [kpd_pkg::ROW_W-1:0]    row_4,
    input  logic [kpd_pkg::ROW_W-1:0]    row_5,
    input  logic [kpd_pkg::ROW_W-1:0]    row_6,
    input  logic [kpd_pkg::ROW_W-1:0]    row_7,
    input  logic [kpd_pkg::ROW_W-1:0]    row_8,
    input  logic [kpd_pkg::ROW_W-1:0]    row_9,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kpd_pkg::CODE_W-1:0]   key_code,
    output logic                         new_key
);
    import kpd_pkg::*;

    logic [ROW_W-1:0]  rows [ROW_COUNT];
    lane_res_t         lanes [ROW_COUNT];
    logic [CODE_W-1:0] found_code;
    logic              is_new;
    logic              in_xfer;
    logic              out_xfer;

    logic [CODE_W-1:0] last_code_reg, last_code_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_new_reg, out_new_next;
    logic [CODE_W-1:0] skid_code_reg, skid_code_next;
    logic              skid_new_reg, skid_new_next;

    assign rows = '{row_1, row_2, row_3, row_4, row_5, row_6, row_7, row_8, row_9};

    for (genvar r = 0; r < ROW_COUNT; r++)
    begin : g_lane
        kpd_lane u_lane (
            .row_idx (ROW_IDX_W'(r)),
            .shifted (~row_1[SHIFT_BIT]),
            .row     (rows[r]),
            .res     (lanes[r])
        );
    end

    kpd_merge u_merge (
        .lanes (lanes),
        .code  (found_code)
    );

    assign is_new   = (found_code != CODE_NONE) && (found_code != last_code_reg);
    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    always_comb
    begin
        last_code_next  = in_xfer ? found_code : last_code_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_code_next   = out_code_reg;
        out_new_next    = out_new_reg;
        skid_code_next  = skid_code_reg;
        skid_new_next   = skid_new_reg;
        if (!out_valid_reg || out_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                out_new_next    = skid_new_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_xfer;
                out_code_next  = is_new ? found_code : CODE_NONE;
                out_new_next   = is_new;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
            skid_code_next  = is_new ? found_code : CODE_NONE;
            skid_new_next   = is_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg  <= CODE_NONE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            last_code_reg  <= last_code_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        out_new_reg   <= out_new_next;
        skid_code_reg <= skid_code_next;
        skid_new_reg  <= skid_new_next;
    end

    assign out_valid = out_valid_reg;
    assign key_code  = out_code_reg;
    assign new_key   = out_new_reg;

    a_new_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_new_reg |-> out_code_reg != CODE_NONE)
        else $error("new key reported with zero code");

    a_old_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_new_reg |-> out_code_reg == CODE_NONE)
        else $error("non-zero code without new key");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_kept_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_new |=> last_code_reg != CODE_NONE)
        else $error("kept code lost after new key");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix scan decoder testbench
// Drives 9x8 key matrix snapshots through keypad_matrix_decoder_core and
// checks every key report against an in-bench scan of both keymaps, with
// random idle and stall cycles, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb;

    import kpd_pkg::*;

    typedef logic [ROW_COUNT-1:0][ROW_W-1:0] snap_t;

    localparam int          SCAN_ROWS  = 9;
    localparam int          SCAN_COLS  = 8;
    localparam int          SHIFT_COL  = 7;
    localparam snap_t       ALL_UP     = '1;
    localparam logic [7:0]  NO_KEY     = 8'h00;
    localparam logic [7:0]  KEY_ESC    = 8'h1b;
    localparam logic [7:0]  KEY_DEL    = 8'h7f;
    localparam logic [7:0]  KEY_TAB    = 8'h09;
    localparam logic [7:0]  KEY_BS     = 8'h08;
    localparam logic [7:0]  KEY_LF     = 8'h0a;
    localparam logic [7:0]  KEY_CR     = 8'h0d;
    localparam logic [7:0]  KEY_F1     = 8'h80;
    localparam logic [7:0]  KEY_F2     = 8'h81;
    localparam logic [7:0]  KEY_F3     = 8'h82;
    localparam logic [7:0]  KEY_F4     = 8'h83;
    localparam logic [7:0]  KEY_F5     = 8'h84;
    localparam logic [7:0]  KEY_F6     = 8'h85;
    localparam logic [7:0]  KEY_F7     = 8'h86;
    localparam logic [7:0]  KEY_INS    = 8'h92;
    localparam logic [7:0]  KEY_UP     = 8'h96;
    localparam logic [7:0]  KEY_DOWN   = 8'h97;
    localparam logic [7:0]  KEY_LEFT   = 8'h98;
    localparam logic [7:0]  KEY_RIGHT  = 8'h99;
    localparam int          RANDOM_ITEMS = 680;
    localparam int          HOLD_CYCLES  = 60;

    localparam logic [7:0] PLAIN_KEYS [0:SCAN_ROWS-1][0:SCAN_COLS-1] = '{
        '{KEY_F7,    KEY_ESC,  KEY_DEL, KEY_LEFT, 8'h71, 8'h61, 8'h60, NO_KEY},
        '{KEY_F6,    KEY_UP,   KEY_INS, 8'h32,    8'h77, 8'h73, 8'h7a, NO_KEY},
        '{KEY_F5,    KEY_F3,   8'h20,   8'h33,    8'h65, 8'h64, 8'h78, NO_KEY},
        '{KEY_F4,    8'h31,    KEY_TAB, 8'h34,    8'h72, 8'h66, 8'h63, 8'h5b},
        '{KEY_RIGHT, KEY_DOWN, KEY_CR,  8'h35,    8'h74, 8'h67, 8'h76, 8'h5d},
        '{KEY_F2,    8'h3b,    KEY_LF,  8'h36,    8'h79, 8'h68, 8'h62, 8'h5c},
        '{KEY_F1,    8'h2f,    KEY_BS,  8'h37,    8'h75, 8'h6a, 8'h6e, NO_KEY},
        '{8'h2d,     8'h2e,    8'h30,   8'h38,    8'h69, 8'h6b, 8'h6d, NO_KEY},
        '{8'h27,     8'h3d,    8'h39,   8'h70,    8'h6f, 8'h6c, 8'h2c, NO_KEY}
    };

    localparam logic [7:0] SHIFT_KEYS [0:SCAN_ROWS-1][0:SCAN_COLS-1] = '{
        '{KEY_F7,    KEY_ESC,  KEY_DEL, KEY_LEFT, 8'h51, 8'h41, 8'h60, NO_KEY},
        '{KEY_F6,    KEY_UP,   KEY_INS, 8'h21,    8'h57, 8'h53, 8'h5a, NO_KEY},
        '{KEY_F5,    KEY_F3,   8'h20,   8'h23,    8'h45, 8'h44, 8'h58, NO_KEY},
        '{KEY_F4,    8'h31,    KEY_TAB, 8'h24,    8'h52, 8'h46, 8'h43, 8'h7b},
        '{KEY_RIGHT, KEY_DOWN, KEY_CR,  8'h25,    8'h54, 8'h47, 8'h56, 8'h7d},
        '{KEY_F2,    8'h3a,    KEY_LF,  8'h5e,    8'h59, 8'h48, 8'h42, 8'h7c},
        '{KEY_F1,    8'h3f,    KEY_BS,  8'h26,    8'h55, 8'h4a, 8'h4e, NO_KEY},
        '{8'h5f,     8'h3e,    8'h29,   8'h2a,    8'h49, 8'h4b, 8'h4d, NO_KEY},
        '{8'h22,     8'h2b,    8'h28,   8'h50,    8'h4f, 8'h4c, 8'h3c, NO_KEY}
    };

    class key_scoreboard;
        logic [7:0] expected_codes [$];
        logic       expected_flags [$];
        logic [7:0] kept_code;
        int         errors;

        function new();
            kept_code = NO_KEY;
            errors    = 0;
        endfunction

        function logic [7:0] first_mapped_code(snap_t s);
            logic       shifted;
            logic [7:0] code;
            shifted = !s[0][SHIFT_COL];
            for (int r = 0; r < SCAN_ROWS; r++)
            begin
                for (int c = 0; c < SCAN_COLS; c++)
                begin
                    if (!s[r][c])
                    begin
                        code = shifted ? SHIFT_KEYS[r][c] : PLAIN_KEYS[r][c];
                        if (code != NO_KEY)
                            return code;
                    end
                end
            end
            return NO_KEY;
        endfunction

        function void note_snapshot(snap_t s);
            logic [7:0] code;
            code = first_mapped_code(s);
            if (code != NO_KEY && code != kept_code)
            begin
                expected_codes.push_back(code);
                expected_flags.push_back(1'b1);
            end
            else
            begin
                expected_codes.push_back(NO_KEY);
                expected_flags.push_back(1'b0);
            end
            kept_code = code;
        endfunction

        function void check_report(logic [7:0] code, logic flag);
            logic [7:0] want_code;
            logic       want_flag;
            if (expected_codes.size() == 0)
            begin
                $display("%0t: unexpected report key_code=%h new_key=%b", $time, code, flag);
                errors++;
                return;
            end
            want_code = expected_codes.pop_front();
            want_flag = expected_flags.pop_front();
            if (code !== want_code)
            begin
                $display("%0t: key_code expected %h actual %h", $time, want_code, code);
                errors++;
            end
            if (flag !== want_flag)
            begin
                $display("%0t: new_key expected %b actual %b", $time, want_flag, flag);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_codes.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    snap_t             rows;
    logic              out_valid;
    logic              out_stall;
    logic [CODE_W-1:0] key_code;
    logic              new_key;

    key_scoreboard sb = new();
    bit            calm;
    int            reports_seen;
    int            items_sent;

    keypad_matrix_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .row_1     (rows[0]),
        .row_2     (rows[1]),
        .row_3     (rows[2]),
        .row_4     (rows[3]),
        .row_5     (rows[4]),
        .row_6     (rows[5]),
        .row_7     (rows[6]),
        .row_8     (rows[7]),
        .row_9     (rows[8]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_code  (key_code),
        .new_key   (new_key)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic snap_t press(snap_t s, int r, int c);
        s[r][c] = 1'b0;
        return s;
    endfunction

    function automatic snap_t random_chord(int keys, bit shift);
        snap_t s;
        s = ALL_UP;
        for (int k = 0; k < keys; k++)
            s[$urandom_range(0, SCAN_ROWS - 1)][$urandom_range(0, SCAN_COLS - 1)] = 1'b0;
        if (shift)
            s[0][SHIFT_COL] = 1'b0;
        return s;
    endfunction

    task automatic send_snapshot(input snap_t s);
        if (!calm && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rows     <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_snapshot(s);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            sb.check_report(key_code, new_key);
            reports_seen++;
        end
    end

    initial
    begin
        bit held_off;
        held_off  = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_off && reports_seen >= 200)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 7)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        snap_t s;
        int    target;
        int    pick;
        bit    paused;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rows         = ALL_UP;
        calm         = 1'b0;
        paused       = 1'b0;
        reports_seen = 0;
        items_sent   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_snapshot(ALL_UP);
        send_snapshot('0);
        send_snapshot('0);
        send_snapshot(press(ALL_UP, 0, SHIFT_COL));
        send_snapshot(press(ALL_UP, 0, 4));
        send_snapshot(press(press(ALL_UP, 0, 4), 0, SHIFT_COL));
        send_snapshot(press(press(ALL_UP, 0, 4), 0, SHIFT_COL));
        send_snapshot(press(ALL_UP, 1, 7));
        send_snapshot(press(press(ALL_UP, 1, 7), 8, 6));
        send_snapshot(press(press(ALL_UP, 0, SHIFT_COL), 8, 0));
        send_snapshot(press(press(ALL_UP, 2, 2), 4, 0));
        send_snapshot(press(ALL_UP, 2, 1));
        send_snapshot(press(ALL_UP, 0, 1));
        send_snapshot(press(press(ALL_UP, 0, 1), 0, SHIFT_COL));
        send_snapshot(ALL_UP);
        send_snapshot(press(ALL_UP, 3, 7));
        send_snapshot(press(press(ALL_UP, 3, 7), 0, SHIFT_COL));
        send_snapshot(press(ALL_UP, 8, 7));
        send_snapshot(press(ALL_UP, 4, 0));
        send_snapshot(press(press(ALL_UP, 8, 3), 0, SHIFT_COL));
        drain_reports();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            calm = (items_sent >= 250 && items_sent < 400);
            if (!paused && items_sent >= 450)
            begin
                paused = 1'b1;
                drain_reports();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                s = random_chord($urandom_range(1, 3), $urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 4)) send_snapshot(s);
                if ($urandom_range(0, 1))
                    send_snapshot(ALL_UP);
            end
            else if (pick < 85)
            begin
                for (int r = 0; r < SCAN_ROWS; r++)
                    s[r] = ROW_W'($urandom_range(0, 255));
                send_snapshot(s);
            end
            else if (pick < 93)
            begin
                for (int r = 0; r < SCAN_ROWS; r++)
                    s[r] = ROW_W'(~($urandom_range(0, 255) & $urandom_range(0, 255)
                                    & $urandom_range(0, 255)));
                send_snapshot(s);
            end
            else
                send_snapshot(ALL_UP);
        end
        calm = 1'b0;

        drain_reports();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/kpd_pkg.sv
hw/rtl/kpd_lane.sv
hw/rtl/kpd_merge.sv
hw/rtl/keypad_matrix_decoder_core.sv
tb/sv/tb.sv
